// File: rtl/gzhp_pkg.sv
// Shared types, codes and helper functions for the gzip member header parser.
// No dependencies; every other file of the block but the two channel interfaces imports it.
`default_nettype none

package gzhp_pkg;

    // Parse phases of the member header walk.
    typedef enum logic [3:0] {
        PH_MAGIC1  = 4'd0,
        PH_MAGIC2  = 4'd1,
        PH_METHOD  = 4'd2,
        PH_FLAGS   = 4'd3,
        PH_FIXED   = 4'd4,
        PH_XLO     = 4'd5,
        PH_XHI     = 4'd6,
        PH_EXTRA   = 4'd7,
        PH_NAME    = 4'd8,
        PH_COMMENT = 4'd9,
        PH_HCRC    = 4'd10,
        PH_IDLE    = 4'd11
    } phase_t;

    // Status codes reported with every result.
    typedef enum logic [2:0] {
        ST_IN_HEADER = 3'd0,
        ST_DONE      = 3'd1,
        ST_NOT_GZIP  = 3'd2,
        ST_BAD       = 3'd3,
        ST_TRUNC     = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_LONE      = 3'd6,
        ST_IDLE      = 3'd7
    } status_t;

    // Item kinds on the input channel; the undefined kind is ignored.
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;
    localparam logic [1:0] KIND_UNDEF   = 2'd3;

    localparam logic [7:0] MAGIC1         = 8'h1f;
    localparam logic [7:0] MAGIC2         = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;
    localparam logic [7:0] FLG_RESERVED   = 8'he0;
    localparam logic [7:0] FLG_EXTRA      = 8'h04;
    localparam logic [7:0] FLG_NAME       = 8'h08;
    localparam logic [7:0] FLG_COMMENT    = 8'h10;
    localparam logic [7:0] FLG_HCRC       = 8'h02;

    // Index of the last of the six fixed bytes (time, extra flags, OS).
    localparam logic [2:0] FIXED_LAST = 3'd5;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  flag_byte;
        logic        method_deflate;
        logic [2:0]  fixed_cnt;
        logic [15:0] extra_left;
    } hdr_state_t;

    typedef struct packed {
        status_t    status;
        logic [1:0] replay_count;
        logic [7:0] header_flags;
    } hdr_result_t;

    // First optional section at or after 'from' whose flag is set.
    function automatic phase_t next_section(phase_t from, logic [7:0] flags);
        phase_t ph;
        ph = PH_IDLE;
        if (from <= PH_XLO && (flags & FLG_EXTRA) != 8'h00)
            ph = PH_XLO;
        else if (from <= PH_NAME && (flags & FLG_NAME) != 8'h00)
            ph = PH_NAME;
        else if (from <= PH_COMMENT && (flags & FLG_COMMENT) != 8'h00)
            ph = PH_COMMENT;
        else if (from <= PH_HCRC && (flags & FLG_HCRC) != 8'h00)
            ph = PH_HCRC;
        return ph;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gzhp_in_if.sv
// Input channel of the header parser: valid/ready handshake with one stream item.
// No dependencies.
`default_nettype none

interface gzhp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/gzhp_out_if.sv
// Result channel of the header parser: valid/ready handshake with one status item.
// No dependencies.
`default_nettype none

interface gzhp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [1:0] replay_count;
    logic [7:0] header_flags;

    modport source (output valid, output status, output replay_count,
                    output header_flags, input ready);
    modport sink   (input valid, input status, input replay_count,
                    input header_flags, output ready);
endinterface

`default_nettype wire

// File: rtl/gzhp_step.sv
// Next-state and result logic for one stream item of the header walk.
// Depends on gzhp_pkg.
`default_nettype none

module gzhp_step (
    input  var gzhp_pkg::hdr_state_t  cur,
    input  var logic [1:0]            kind,
    input  var logic [7:0]            in_byte,
    output var gzhp_pkg::hdr_state_t  nxt,
    output var gzhp_pkg::hdr_result_t res
);
    import gzhp_pkg::*;

    logic    active;
    phase_t  sect;
    status_t status;
    logic [1:0]  replay;
    logic [15:0] extra_new;

    always_comb
    begin
        nxt       = cur;
        status    = ST_IN_HEADER;
        replay    = 2'd0;
        sect      = PH_IDLE;
        extra_new = cur.extra_left;
        active    = (cur.phase < PH_IDLE);

        priority if (kind == KIND_RESTART)
        begin
            nxt.phase          = PH_MAGIC1;
            nxt.flag_byte      = 8'h00;
            nxt.method_deflate = 1'b0;
            nxt.fixed_cnt      = 3'd0;
            nxt.extra_left     = 16'd0;
            status             = ST_IDLE;
        end
        else if (kind != KIND_DATA && kind != KIND_END)
        begin
            status = active ? ST_IN_HEADER : ST_IDLE;
        end
        else if (!active)
        begin
            status = ST_IDLE;
        end
        else if (kind == KIND_END)
        begin
            if (cur.phase == PH_MAGIC1)
                status = ST_EMPTY;
            else if (cur.phase == PH_MAGIC2)
            begin
                status = ST_LONE;
                replay = 2'd1;
            end
            else
                status = ST_TRUNC;
            nxt.phase = PH_IDLE;
        end
        else
        begin
            // A data byte. 'sect' is the phase entered when a section ends.
            sect = cur.phase;
            unique case (cur.phase)
                PH_MAGIC1:
                begin
                    if (in_byte == MAGIC1)
                        nxt.phase = PH_MAGIC2;
                    else
                    begin
                        status    = ST_NOT_GZIP;
                        replay    = 2'd1;
                        nxt.phase = PH_IDLE;
                    end
                end
                PH_MAGIC2:
                begin
                    if (in_byte == MAGIC2)
                        nxt.phase = PH_METHOD;
                    else
                    begin
                        status    = ST_NOT_GZIP;
                        replay    = 2'd2;
                        nxt.phase = PH_IDLE;
                    end
                end
                PH_METHOD:
                begin
                    nxt.method_deflate = (in_byte == METHOD_DEFLATE);
                    nxt.phase          = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    nxt.flag_byte = in_byte;
                    if (!cur.method_deflate || (in_byte & FLG_RESERVED) != 8'h00)
                    begin
                        status    = ST_BAD;
                        nxt.phase = PH_IDLE;
                    end
                    else
                    begin
                        nxt.phase     = PH_FIXED;
                        nxt.fixed_cnt = 3'd0;
                    end
                end
                PH_FIXED:
                begin
                    if (cur.fixed_cnt >= FIXED_LAST)
                    begin
                        sect          = next_section(PH_XLO, cur.flag_byte);
                        nxt.phase     = sect;
                        nxt.fixed_cnt = 3'd0;
                        status        = (sect == PH_IDLE) ? ST_DONE : ST_IN_HEADER;
                    end
                    else
                        nxt.fixed_cnt = cur.fixed_cnt + 3'd1;
                end
                PH_XLO:
                begin
                    nxt.extra_left = {8'h00, in_byte};
                    nxt.phase      = PH_XHI;
                end
                PH_XHI:
                begin
                    extra_new      = {in_byte, cur.extra_left[7:0]};
                    nxt.extra_left = extra_new;
                    if (extra_new == 16'd0)
                    begin
                        sect          = next_section(PH_NAME, cur.flag_byte);
                        nxt.phase     = sect;
                        nxt.fixed_cnt = 3'd0;
                        status        = (sect == PH_IDLE) ? ST_DONE : ST_IN_HEADER;
                    end
                    else
                        nxt.phase = PH_EXTRA;
                end
                PH_EXTRA:
                begin
                    extra_new      = cur.extra_left - 16'd1;
                    nxt.extra_left = extra_new;
                    if (extra_new == 16'd0)
                    begin
                        sect          = next_section(PH_NAME, cur.flag_byte);
                        nxt.phase     = sect;
                        nxt.fixed_cnt = 3'd0;
                        status        = (sect == PH_IDLE) ? ST_DONE : ST_IN_HEADER;
                    end
                end
                PH_NAME:
                begin
                    if (in_byte == 8'h00)
                    begin
                        sect          = next_section(PH_COMMENT, cur.flag_byte);
                        nxt.phase     = sect;
                        nxt.fixed_cnt = 3'd0;
                        status        = (sect == PH_IDLE) ? ST_DONE : ST_IN_HEADER;
                    end
                end
                PH_COMMENT:
                begin
                    if (in_byte == 8'h00)
                    begin
                        sect          = next_section(PH_HCRC, cur.flag_byte);
                        nxt.phase     = sect;
                        nxt.fixed_cnt = 3'd0;
                        status        = (sect == PH_IDLE) ? ST_DONE : ST_IN_HEADER;
                    end
                end
                PH_HCRC:
                begin
                    if (cur.fixed_cnt >= 3'd1)
                    begin
                        nxt.phase     = PH_IDLE;
                        nxt.fixed_cnt = 3'd0;
                        status        = ST_DONE;
                    end
                    else
                        nxt.fixed_cnt = 3'd1;
                end
                default:
                begin
                    status = ST_IDLE;
                end
            endcase
        end

        res.status       = status;
        res.replay_count = replay;
        res.header_flags = nxt.flag_byte;
    end

endmodule

`default_nettype wire

// File: rtl/gzhp_core_if_note.sv
// Header phase register and result register of the parser, kept as one stage.
// Depends on gzhp_pkg and gzhp_step.
`default_nettype none

module gzhp_stage (
    input  var logic                  clk,
    input  var logic                  rst_n,
    input  var logic                  load,
    input  var logic                  drain,
    input  var logic [1:0]            kind,
    input  var logic [7:0]            in_byte,
    output var logic                  res_valid,
    output var gzhp_pkg::hdr_result_t res,
    output var gzhp_pkg::phase_t      phase
);
    import gzhp_pkg::*;

    hdr_state_t  state_reg;
    hdr_state_t  state_next;
    hdr_result_t res_reg;
    hdr_result_t res_next;
    logic        valid_reg;

    gzhp_step u_step (
        .cur     (state_reg),
        .kind    (kind),
        .in_byte (in_byte),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= PH_MAGIC1;
            state_reg.flag_byte      <= 8'h00;
            state_reg.method_deflate <= 1'b0;
            state_reg.fixed_cnt      <= 3'd0;
            state_reg.extra_left     <= 16'd0;
            valid_reg                <= 1'b0;
        end
        else
        begin
            if (load)
                state_reg <= state_next;
            if (load)
                valid_reg <= 1'b1;
            else if (drain)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;
    assign phase     = state_reg.phase;

    // Replay bytes only ever accompany a non-gzip or lone-magic report.
    a_replay_status: assert property (@(posedge clk) disable iff (!rst_n)
        load && res_next.replay_count != 2'd0
        |-> res_next.status == ST_NOT_GZIP || res_next.status == ST_LONE)
        else $error("replay count with unexpected status");

    // Any terminal report leaves the walk idle until a restart.
    a_error_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load && res_next.status != ST_IN_HEADER && res_next.status != ST_IDLE
        |=> state_reg.phase == PH_IDLE)
        else $error("terminal status without going idle");

    // A restart leaves a fresh walk and an idle report with no flags.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load && kind == KIND_RESTART
        |=> state_reg.phase == PH_MAGIC1 && valid_reg && res_reg.status == ST_IDLE
            && res_reg.header_flags == 8'h00)
        else $error("restart not taken");

endmodule

`default_nettype wire

// File: rtl/gzip_member_header_parser_core.sv
// Top level of the gzip member header parser: channel handshakes around one stage.
// Depends on gzhp_pkg, gzhp_in_if, gzhp_out_if and gzhp_stage.
//
// Usage: the source presents one item per transfer on 'item': a stream byte
// (kind 0), end of input data (kind 1) or a restart before the next member
// header (kind 2). Every accepted item produces exactly one transfer on
// 'result' carrying a status code, a replay count for bytes that turned out
// to be payload, and the header flag byte once it has been seen.
// The result is registered: the result of an item accepted at one clock edge is
// valid after that edge. Throughput is one item per cycle while the sink takes
// results; the single result register is refilled in the same cycle that the
// sink takes its transfer. When the sink stalls, the result register holds and
// 'item.ready' drops until the register is emptied, so nothing is lost or
// repeated. Reset clears the walk to waiting for the first magic byte with no
// flags seen, and empties the result register. After a header completes or an
// error is reported, bytes and end markers report idle until a restart.
`default_nettype none

module gzip_member_header_parser_core (
    input  var logic   clk,
    input  var logic   rst_n,
    gzhp_in_if.sink    item,
    gzhp_out_if.source result
);
    import gzhp_pkg::*;

    logic        load;
    logic        drain;
    logic        res_valid;
    hdr_result_t res;
    phase_t      phase;

    assign drain      = result.valid && result.ready;
    assign item.ready = !res_valid || result.ready;
    assign load       = item.valid && item.ready;

    gzhp_stage u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .drain     (drain),
        .kind      (item.kind),
        .in_byte   (item.in_byte),
        .res_valid (res_valid),
        .res       (res),
        .phase     (phase)
    );

    assign result.valid        = res_valid;
    assign result.status       = res.status;
    assign result.replay_count = res.replay_count;
    assign result.header_flags = res.header_flags;

    // Every accepted item leaves a result waiting in the next cycle.
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result.valid)
        else $error("accepted item produced no result");

    // An item is never taken while an untaken result would be overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !load)
        else $error("result overwritten while stalled");

    // While idle, only a restart brings the walk back into a header.
    a_idle_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase == PH_IDLE && !(load && item.kind == KIND_RESTART)
        |=> phase == PH_IDLE)
        else $error("left idle without restart");

endmodule

`default_nettype wire

// File: tb/gzhp_status_checker.sv
// Checker for the gzip member header parser: watches both channels, predicts each status
// transfer from the accepted stream items and compares it field by field.
// Depends on gzhp_pkg and the gzhp_in_if / gzhp_out_if interfaces.
module gzhp_status_checker (
    input  var logic clk,
    input  var logic rst_n,
    gzhp_in_if       item,
    gzhp_out_if      result,
    output int       errors,
    output int       pending
);
    import gzhp_pkg::*;

    // Predicted state of the header walk.
    phase_t      walk_phase;
    logic [7:0]  walk_flags;
    logic        walk_deflate;
    logic [2:0]  walk_count;
    logic [15:0] walk_extra;

    hdr_result_t awaited_status_q[$];

    task automatic clear_walk();
        walk_phase   = PH_MAGIC1;
        walk_flags   = 8'h00;
        walk_deflate = 1'b0;
        walk_count   = 3'd0;
        walk_extra   = 16'd0;
    endtask

    task automatic report_failure(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Later sections are checked first so that the earliest flagged one wins.
    function automatic phase_t section_from(input phase_t from);
        phase_t nxt;
        nxt = PH_IDLE;
        if (from <= PH_HCRC && (walk_flags & FLG_HCRC) != 8'h00)
            nxt = PH_HCRC;
        if (from <= PH_COMMENT && (walk_flags & FLG_COMMENT) != 8'h00)
            nxt = PH_COMMENT;
        if (from <= PH_NAME && (walk_flags & FLG_NAME) != 8'h00)
            nxt = PH_NAME;
        if (from <= PH_XLO && (walk_flags & FLG_EXTRA) != 8'h00)
            nxt = PH_XLO;
        return nxt;
    endfunction

    function automatic status_t enter_section(input phase_t ph);
        walk_phase = ph;
        walk_count = 3'd0;
        return (ph == PH_IDLE) ? ST_DONE : ST_IN_HEADER;
    endfunction

    task automatic predict_status(input logic [1:0] kind, input logic [7:0] b,
                                  output hdr_result_t res);
        status_t    st;
        logic [1:0] replay;
        logic       active;
        st     = ST_IN_HEADER;
        replay = 2'd0;
        active = (walk_phase < PH_IDLE);
        if (kind == KIND_RESTART)
        begin
            clear_walk();
            st = ST_IDLE;
        end
        else if (kind == KIND_UNDEF)
        begin
            st = active ? ST_IN_HEADER : ST_IDLE;
        end
        else if (!active)
        begin
            st = ST_IDLE;
        end
        else if (kind == KIND_END)
        begin
            if (walk_phase == PH_MAGIC1)
                st = ST_EMPTY;
            else if (walk_phase == PH_MAGIC2)
            begin
                st     = ST_LONE;
                replay = 2'd1;
            end
            else
                st = ST_TRUNC;
            walk_phase = PH_IDLE;
        end
        else
        begin
            case (walk_phase)
                PH_MAGIC1:
                begin
                    if (b == MAGIC1)
                        walk_phase = PH_MAGIC2;
                    else
                    begin
                        st         = ST_NOT_GZIP;
                        replay     = 2'd1;
                        walk_phase = PH_IDLE;
                    end
                end
                PH_MAGIC2:
                begin
                    if (b == MAGIC2)
                        walk_phase = PH_METHOD;
                    else
                    begin
                        st         = ST_NOT_GZIP;
                        replay     = 2'd2;
                        walk_phase = PH_IDLE;
                    end
                end
                PH_METHOD:
                begin
                    walk_deflate = (b == METHOD_DEFLATE);
                    walk_phase   = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    walk_flags = b;
                    if (!walk_deflate || (b & FLG_RESERVED) != 8'h00)
                    begin
                        st         = ST_BAD;
                        walk_phase = PH_IDLE;
                    end
                    else
                    begin
                        walk_phase = PH_FIXED;
                        walk_count = 3'd0;
                    end
                end
                PH_FIXED:
                begin
                    if (walk_count >= FIXED_LAST)
                        st = enter_section(section_from(PH_XLO));
                    else
                        walk_count = walk_count + 3'd1;
                end
                PH_XLO:
                begin
                    walk_extra = {8'h00, b};
                    walk_phase = PH_XHI;
                end
                PH_XHI:
                begin
                    walk_extra = {b, walk_extra[7:0]};
                    if (walk_extra == 16'd0)
                        st = enter_section(section_from(PH_NAME));
                    else
                        walk_phase = PH_EXTRA;
                end
                PH_EXTRA:
                begin
                    walk_extra = walk_extra - 16'd1;
                    if (walk_extra == 16'd0)
                        st = enter_section(section_from(PH_NAME));
                end
                PH_NAME:
                begin
                    if (b == 8'h00)
                        st = enter_section(section_from(PH_COMMENT));
                end
                PH_COMMENT:
                begin
                    if (b == 8'h00)
                        st = enter_section(section_from(PH_HCRC));
                end
                PH_HCRC:
                begin
                    if (walk_count >= 3'd1)
                        st = enter_section(PH_IDLE);
                    else
                        walk_count = 3'd1;
                end
                default:
                    st = ST_IDLE;
            endcase
        end
        res.status       = st;
        res.replay_count = replay;
        res.header_flags = walk_flags;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
        clear_walk();
    end

    // A status transfer belongs to an item accepted at an earlier edge, so it is
    // checked before this edge's item is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        hdr_result_t want;
        if (!rst_n)
        begin
            clear_walk();
            awaited_status_q.delete();
            pending = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (awaited_status_q.size() == 0)
                    report_failure($sformatf("status transfer %0d with nothing awaited",
                                             result.status));
                else
                begin
                    want = awaited_status_q.pop_front();
                    if (result.status !== want.status)
                        report_failure($sformatf("status: got %0d, want %0d",
                                                 result.status, want.status));
                    if (result.replay_count !== want.replay_count)
                        report_failure($sformatf("replay_count: got %0d, want %0d",
                                                 result.replay_count, want.replay_count));
                    if (result.header_flags !== want.header_flags)
                        report_failure($sformatf("header_flags: got %h, want %h",
                                                 result.header_flags, want.header_flags));
                end
            end
            if (item.valid && item.ready)
            begin
                predict_status(item.kind, item.in_byte, want);
                awaited_status_q.push_back(want);
            end
            pending = awaited_status_q.size();
        end
    end
endmodule

// File: tb/testbench.sv
// Top of the header parser testbench: clock, reset, stream stimulus and the verdict.
// Depends on gzhp_pkg, both channel interfaces, the parser core and gzhp_status_checker.
module testbench;
    import gzhp_pkg::*;

    localparam int ITEM_GOAL           = 2000;
    localparam int QUIET_FROM          = 1800;
    localparam int LONG_HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES       = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        bit         counts;
    } stream_item_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;

    gzhp_in_if  item_ch ();
    gzhp_out_if result_ch ();

    gzip_member_header_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    gzhp_status_checker status_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .errors  (errors),
        .pending (pending)
    );

    stream_item_t stream_q[$];
    int           sent_items;
    int           hold_requests;
    bit           quiet;
    bit           gappy;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic queue_item(input logic [1:0] k, input logic [7:0] b);
        stream_q.push_back('{kind: k, data: b, counts: 1'b1});
    endtask

    // Items the parser only answers with idle or ignores.
    task automatic queue_idle_item(input logic [1:0] k, input logic [7:0] b);
        stream_q.push_back('{kind: k, data: b, counts: 1'b0});
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic offer(input logic [1:0] k, input logic [7:0] b);
        item_ch.valid   <= 1'b1;
        item_ch.kind    <= k;
        item_ch.in_byte <= b;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        item_ch.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic play_stream();
        stream_item_t s;
        while (stream_q.size() != 0)
        begin
            s = stream_q.pop_front();
            if ($urandom_range(0, 29) == 0)
                offer(KIND_UNDEF, any_byte());
            offer(s.kind, s.data);
            if (s.counts)
                sent_items++;
            if (gappy && !quiet && $urandom_range(0, 5) == 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    task automatic queue_member();
        int         mode;
        int         start;
        int         keep;
        int         xlen;
        logic [7:0] method;
        logic [7:0] flags;
        bit         cut;
        mode = $urandom_range(0, 99);
        queue_item(KIND_RESTART, any_byte());
        start = stream_q.size();
        if (mode < 70)
        begin
            cut    = ($urandom_range(0, 5) == 0);
            method = ($urandom_range(0, 15) == 0) ? any_byte() : METHOD_DEFLATE;
            flags  = 8'($urandom_range(0, 31));
            if ($urandom_range(0, 15) == 0)
                flags[7:5] = 3'($urandom_range(1, 7));
            queue_item(KIND_DATA, MAGIC1);
            queue_item(KIND_DATA, MAGIC2);
            queue_item(KIND_DATA, method);
            queue_item(KIND_DATA, flags);
            // A rejected header leaves the parser idle; nothing more is worth sending.
            if (method != METHOD_DEFLATE || (flags & FLG_RESERVED) != 8'h00)
                return;
            repeat (6) queue_item(KIND_DATA, any_byte());
            if ((flags & FLG_EXTRA) != 8'h00)
            begin
                xlen = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 6);
                queue_item(KIND_DATA, xlen[7:0]);
                queue_item(KIND_DATA, xlen[15:8]);
                // Long extra fields are cut short so the run stays fast.
                if (xlen > 40)
                begin
                    repeat ($urandom_range(0, 8)) queue_item(KIND_DATA, any_byte());
                    queue_item(KIND_END, any_byte());
                    return;
                end
                repeat (xlen) queue_item(KIND_DATA, any_byte());
            end
            if ((flags & FLG_NAME) != 8'h00)
            begin
                repeat ($urandom_range(0, 5)) queue_item(KIND_DATA, 8'($urandom_range(1, 255)));
                queue_item(KIND_DATA, 8'h00);
            end
            if ((flags & FLG_COMMENT) != 8'h00)
            begin
                repeat ($urandom_range(0, 5)) queue_item(KIND_DATA, 8'($urandom_range(1, 255)));
                queue_item(KIND_DATA, 8'h00);
            end
            if ((flags & FLG_HCRC) != 8'h00)
                repeat (2) queue_item(KIND_DATA, any_byte());
            if (cut)
            begin
                keep = $urandom_range(start, stream_q.size() - 1);
                while (stream_q.size() > keep)
                    void'(stream_q.pop_back());
                queue_item(KIND_END, any_byte());
            end
        end
        else if (mode < 85)
        begin
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(0, 3))
                    0: queue_item(KIND_DATA, ($urandom_range(0, 2) == 0) ? MAGIC1 : any_byte());
                    1: queue_item(KIND_END, any_byte());
                    2: queue_item(KIND_RESTART, any_byte());
                    default: queue_idle_item(KIND_UNDEF, any_byte());
                endcase
            end
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: queue_item(KIND_DATA, any_byte());
                1:
                begin
                    queue_item(KIND_DATA, MAGIC1);
                    queue_item(KIND_DATA, any_byte());
                end
                2:
                begin
                    queue_item(KIND_DATA, MAGIC1);
                    queue_item(KIND_END, any_byte());
                end
                default: queue_item(KIND_END, any_byte());
            endcase
        end
    endtask

    task automatic queue_tail_noise();
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 2))
                0: queue_idle_item(KIND_DATA, any_byte());
                1: queue_idle_item(KIND_END, any_byte());
                default: queue_idle_item(KIND_UNDEF, any_byte());
            endcase
        end
    endtask

    task automatic queue_directed();
        // End of data straight after reset: the stream is empty.
        queue_item(KIND_END, 8'h00);
        // A lone first magic byte followed by end of data.
        queue_item(KIND_RESTART, 8'hff);
        queue_item(KIND_DATA, MAGIC1);
        queue_item(KIND_END, 8'hff);
        // Not gzip at the first and at the second magic byte.
        queue_item(KIND_RESTART, 8'h00);
        queue_item(KIND_DATA, 8'h00);
        queue_item(KIND_RESTART, 8'h55);
        queue_item(KIND_DATA, MAGIC1);
        queue_item(KIND_DATA, 8'hff);
        // Reserved flag bits set.
        queue_item(KIND_RESTART, 8'haa);
        queue_item(KIND_DATA, MAGIC1);
        queue_item(KIND_DATA, MAGIC2);
        queue_item(KIND_DATA, METHOD_DEFLATE);
        queue_item(KIND_DATA, 8'hff);
        // Every optional section, with an empty extra field, name and comment.
        queue_item(KIND_RESTART, 8'h00);
        queue_item(KIND_DATA, MAGIC1);
        queue_item(KIND_DATA, MAGIC2);
        queue_item(KIND_DATA, METHOD_DEFLATE);
        queue_item(KIND_DATA, 8'h1f);
        queue_item(KIND_DATA, 8'h00);
        queue_item(KIND_DATA, 8'hff);
        queue_item(KIND_DATA, 8'h55);
        queue_idle_item(KIND_UNDEF, 8'hff);
        queue_item(KIND_DATA, 8'haa);
        queue_item(KIND_DATA, 8'h00);
        queue_item(KIND_DATA, 8'hff);
        queue_item(KIND_DATA, 8'h00);
        queue_item(KIND_DATA, 8'h00);
        queue_item(KIND_DATA, 8'h00);
        queue_item(KIND_DATA, 8'h00);
        queue_item(KIND_DATA, 8'h12);
        queue_item(KIND_DATA, 8'h34);
        // After the header everything but a restart reports idle.
        queue_idle_item(KIND_DATA, 8'hff);
        queue_idle_item(KIND_END, 8'h00);
        queue_idle_item(KIND_UNDEF, 8'h00);
    endtask

    // Result side: random stall bursts, calm stretches, and long hold-offs on request.
    initial
    begin
        int stall_left;
        int holds_done;
        bit calm;
        stall_left      = 0;
        holds_done      = 0;
        calm            = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (holds_done != hold_requests)
            begin
                holds_done++;
                stall_left = LONG_HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!quiet && !calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int member_no;
        sent_items      = 0;
        hold_requests   = 0;
        quiet           = 1'b0;
        gappy           = 1'b0;
        member_no       = 0;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.kind    = KIND_DATA;
        item_ch.in_byte = 8'h00;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        play_stream();

        while (sent_items < ITEM_GOAL)
        begin
            quiet = (sent_items >= QUIET_FROM);
            gappy = !quiet && ($urandom_range(0, 2) != 0);
            if (!quiet && member_no % 60 == 10)
                hold_requests++;
            if (!quiet && member_no % 60 == 40)
            begin
                // Let the parser drain completely before the next member.
                pause_sender(1);
                while (pending != 0)
                    @(negedge clk);
            end
            queue_member();
            queue_tail_noise();
            play_stream();
            member_no++;
        end

        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: sim.f
rtl/gzhp_pkg.sv
rtl/gzhp_in_if.sv
rtl/gzhp_out_if.sv
rtl/gzhp_step.sv
rtl/gzhp_core_if_note.sv
rtl/gzip_member_header_parser_core.sv
tb/gzhp_status_checker.sv
tb/testbench.sv
